>>> sv/assert_macros.svh
// Assertion macros shared by the Huffman bit decoder RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define HBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true outside reset
`define HBD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> sv/hbd_pkg.sv
// Shared types and constants of the Huffman tree bit decoder.
// No dependencies; imported by every module of the block.
package hbd_pkg;

  // Default parameter values
  localparam int NODE_COUNT_DEF  = 512;
  localparam int SYMBOL_BITS_DEF = 8;

  // Field widths
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int DATA_W     = 8;
  localparam int CNT_W      = 24;
  localparam int QUAL_W     = 4;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam int RUN_W      = 4;

  // Arithmetic constants
  localparam int BYTE_BITS = 8;
  localparam int MULT_BASE = 11;

  // Command queue depth (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Input op codes
  localparam logic OP_NODE = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Result status codes
  localparam logic STATUS_SYMBOL    = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 8'd1;

  typedef enum logic {
    CMD_NODE,
    CMD_BYTE
  } cmd_kind_e;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  node_index;
    logic              node_is_leaf;
    logic [SYM_W-1:0]  node_symbol;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic [DATA_W-1:0] data_byte;
    logic              final_byte;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             status;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [IDX_W-1:0]  node_index;
    logic              node_is_leaf;
    logic [SYM_W-1:0]  node_symbol;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic [DATA_W-1:0] data_byte;
    logic              final_byte;
  } cmd_t;

  typedef struct packed {
    logic [QUAL_W-1:0] quality_level;
    logic [CNT_W-1:0]  symbol_total;
  } cfg_t;

endpackage

>>> sv/hbd_front.sv
// Front end: accepts commands, drops out-of-range node writes, holds config.
// Depends on hbd_pkg; feeds hbd_fifo and hands config to hbd_back.
module hbd_front import hbd_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  in_t                   item_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output cmd_t                  q_cmd_o,
  output cfg_t                  cfg_o
);

  localparam logic [31:0] NODE_LIM = 32'(NODE_COUNT);

  logic              accept;
  logic              node_ok;
  logic [QUAL_W-1:0] quality_q, quality_d;
  logic [CNT_W-1:0]  total_q, total_d;

  // Command side: accept when queue has room, classify the beat
  always_comb begin
    accept  = start_i && !q_full_i;
    node_ok = (item_i.op == OP_BYTE) || (32'(item_i.node_index) < NODE_LIM);
    q_push_o = accept && node_ok;
    q_cmd_o.kind         = (item_i.op == OP_BYTE) ? CMD_BYTE : CMD_NODE;
    q_cmd_o.node_index   = item_i.node_index;
    q_cmd_o.node_is_leaf = item_i.node_is_leaf;
    q_cmd_o.node_symbol  = item_i.node_symbol;
    q_cmd_o.left_child   = item_i.left_child;
    q_cmd_o.right_child  = item_i.right_child;
    q_cmd_o.data_byte    = item_i.data_byte;
    q_cmd_o.final_byte   = item_i.final_byte;
  end

  assign busy_o      = q_full_i;
  assign cfg_ready_o = 1'b1;

  // Config register writes
  always_comb begin
    quality_d = quality_q;
    total_d   = total_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_QUALITY) begin
        quality_d = cfg_data_i[QUAL_W-1:0];
      end else if (cfg_index_i == CFG_TOTAL) begin
        total_d = cfg_data_i[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quality_q <= QUAL_W'(1);
      total_q   <= '0;
    end else begin
      quality_q <= quality_d;
      total_q   <= total_d;
    end
  end

  assign cfg_o.quality_level = quality_q;
  assign cfg_o.symbol_total  = total_q;

endmodule

>>> sv/hbd_fifo.sv
// Short command queue between the front end and the tree walker.
// Depends on hbd_pkg for cmd_t and QUEUE_DEPTH.
`include "assert_macros.svh"
module hbd_fifo import hbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FULL_CNT);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_QW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  `HBD_ASSERT_NEVER(a_no_overflow, push_i && full_o, "command pushed into full queue")

endmodule

>>> sv/hbd_back.sv
// Tree walker: node table, one branch or one deferred leaf per cycle, result hold and output stage.
// Depends on hbd_pkg; pops commands from hbd_fifo.
`include "assert_macros.svh"
module hbd_back import hbd_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic q_empty_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [31:0] NODE_LIM = 32'(NODE_COUNT);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BITS  = 2'd1;
  localparam logic [1:0] S_END   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  typedef struct packed {
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
    logic [IDX_W-1:0]       left;
    logic [IDX_W-1:0]       right;
  } entry_t;

  // Node table and its registered read port
  entry_t node_mem [NODE_COUNT];
  entry_t rdata_q;
  entry_t root_q, root_d;

  logic [1:0]        state_q, state_d;
  logic [DATA_W-1:0] byte_q, byte_d;
  logic              final_q, final_d;
  logic [RUN_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [RUN_W-1:0]  n_q, n_d;
  logic              at_root_q, at_root_d;
  logic [CNT_W-1:0]  emitted_q, emitted_d;

  logic              held_valid_q, held_valid_d;
  logic [PIX_W-1:0]  held_pix_q;
  logic              held_status_q;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic                   wr_en, rd_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  entry_t                 wr_entry, cur_e;
  logic                   pend, done, bit_v;
  logic [IDX_W-1:0]       nxt_idx;
  logic                   new_valid, new_err, flush;
  logic [SYMBOL_BITS-1:0] new_sym;
  logic [PIX_W-1:0]       sym8, mult, new_pix;

  // Walk control: one branch or one deferred leaf per cycle
  always_comb begin
    state_d   = state_q;
    byte_d    = byte_q;
    final_d   = final_q;
    bit_cnt_d = bit_cnt_q;
    n_d       = n_q;
    at_root_d = at_root_q;
    emitted_d = emitted_q;
    root_d    = root_q;
    q_pop_o   = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    new_valid = 1'b0;
    new_err   = 1'b0;
    new_sym   = '0;
    flush     = 1'b0;

    wr_addr  = AW'(q_cmd_i.node_index);
    wr_entry.leaf  = q_cmd_i.node_is_leaf;
    wr_entry.sym   = SYMBOL_BITS'(q_cmd_i.node_symbol);
    wr_entry.left  = q_cmd_i.left_child;
    wr_entry.right = q_cmd_i.right_child;

    cur_e   = at_root_q ? root_q : rdata_q;
    pend    = !at_root_q && rdata_q.leaf;
    done    = (emitted_q >= cfg_i.symbol_total);
    bit_v   = byte_q[DATA_W-1];
    nxt_idx = bit_v ? cur_e.right : cur_e.left;
    rd_addr = AW'(nxt_idx);

    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.kind == CMD_NODE) begin
            wr_en     = 1'b1;
            at_root_d = 1'b1;
            emitted_d = '0;
            if (q_cmd_i.node_index == '0) begin
              root_d = wr_entry;
            end
          end else begin
            byte_d    = q_cmd_i.data_byte;
            final_d   = q_cmd_i.final_byte;
            bit_cnt_d = RUN_W'(BYTE_BITS);
            n_d       = '0;
            state_d   = S_BITS;
          end
        end
      end
      S_BITS: begin
        priority if (pend) begin
          // leaf reached by the previous branch
          new_valid = 1'b1;
          new_sym   = rdata_q.sym;
          emitted_d = emitted_q + CNT_W'(1);
          n_d       = n_q + RUN_W'(1);
          at_root_d = 1'b1;
        end else if (bit_cnt_q != '0 && !done) begin
          byte_d    = byte_q << 1;
          bit_cnt_d = bit_cnt_q - RUN_W'(1);
          if (cur_e.leaf) begin
            // leaf at the root: every bit emits it
            new_valid = 1'b1;
            new_sym   = cur_e.sym;
            emitted_d = emitted_q + CNT_W'(1);
            n_d       = n_q + RUN_W'(1);
            at_root_d = 1'b1;
          end else if (32'(nxt_idx) >= NODE_LIM) begin
            at_root_d = 1'b1;
          end else if (nxt_idx == '0) begin
            // branch back to the root: root copy answers at once
            at_root_d = 1'b1;
            if (root_q.leaf) begin
              new_valid = 1'b1;
              new_sym   = root_q.sym;
              emitted_d = emitted_q + CNT_W'(1);
              n_d       = n_q + RUN_W'(1);
            end
          end else begin
            rd_en     = 1'b1;
            at_root_d = 1'b0;
          end
        end else begin
          state_d = S_END;
        end
      end
      S_END: begin
        if (final_q) begin
          at_root_d = 1'b1;
          if (!done && !at_root_q && (n_q < RUN_W'(BYTE_BITS))) begin
            new_valid = 1'b1;
            new_err   = 1'b1;
            n_d       = n_q + RUN_W'(1);
            state_d   = S_FLUSH;
          end else begin
            flush   = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          flush   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FLUSH: begin
        flush   = 1'b1;
        state_d = S_IDLE;
      end
    endcase
  end

  // Pixel scaling: symbol times (11 - quality), low byte
  always_comb begin
    mult    = PIX_W'(MULT_BASE) - PIX_W'(cfg_i.quality_level);
    sym8    = PIX_W'(new_sym);
    new_pix = new_err ? '0 : sym8 * mult;
  end

  // One-result hold so the last beat of a byte can be marked
  always_comb begin
    res_valid_d = held_valid_q && (new_valid || flush);
    res_d.pixel_value = held_pix_q;
    res_d.status      = held_status_q;
    res_d.last_of_run = flush;
    held_valid_d = held_valid_q;
    if (new_valid) begin
      held_valid_d = 1'b1;
    end else if (flush) begin
      held_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bit_cnt_q    <= '0;
      n_q          <= '0;
      at_root_q    <= 1'b1;
      emitted_q    <= '0;
      final_q      <= 1'b0;
      held_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_cnt_q    <= bit_cnt_d;
      n_q          <= n_d;
      at_root_q    <= at_root_d;
      emitted_q    <= emitted_d;
      final_q      <= final_d;
      held_valid_q <= held_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    root_q <= root_d;
    res_q  <= res_d;
    if (new_valid) begin
      held_pix_q    <= new_pix;
      held_status_q <= new_err ? STATUS_EXHAUSTED : STATUS_SYMBOL;
    end
  end

  // Node table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rdata_q <= node_mem[rd_addr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `HBD_ASSERT(a_idle_no_held, (state_q == S_IDLE) |-> !held_valid_q, "result held while idle")
  `HBD_ASSERT(a_run_bound, n_q <= RUN_W'(BYTE_BITS), "more than eight results for one byte")
  `HBD_ASSERT(a_read_walks, rd_en |=> !at_root_q, "table read without leaving the root")
  `HBD_ASSERT(a_held_released, (new_valid && held_valid_q) |=> (res_valid_q && !res_o.last_of_run),
              "displaced result not sent")

endmodule

>>> sv/huffman_tree_bit_decoder_top.sv
// Channel     | Handshake                   | Payload
// ------------+-----------------------------+--------------------------------
// command     | start / busy                | item_i (in_t)
// config      | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
// result      | res_valid_o (strobe)        | res_o (res_t)
//
// The walker takes a node write in its idle state. A byte passes through the
// bit and end states, and a flush state after an exhausted error; each bit is
// one branch, and a leaf reached via the single table read port adds a step.
// Reset clears the walk to the root and the symbol count; the node table is
// not cleared. start is taken while the two-entry command queue has room.
// Each result is on res_o for one cycle under res_valid_o; no backpressure.
module huffman_tree_bit_decoder_top import hbd_pkg::*; #(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   item_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd_in, q_cmd_out;
  cfg_t cfg;

  // Front end: accept and classify
  hbd_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .item_i     (item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in),
    .cfg_o      (cfg)
  );

  // Command queue
  hbd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd_out),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // Tree walker and result stage
  hbd_back #(
    .NODE_COUNT (NODE_COUNT),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_cmd_out),
    .q_pop_o    (q_pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

>>> sim/hbd_stream_checker.sv
// Checker for the Huffman tree bit decoder: mirrors the node table, the walk
// and both registers, predicts every result beat and compares it on the strobe.
// Depends on hbd_pkg; instantiated beside the block by the testbench top.
module hbd_stream_checker import hbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  in_t                   item_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  res_valid_i,
  input  res_t                  res_i,
  output int                    mismatch_cnt_o,
  output int                    pending_o
);

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } tree_entry_t;

  // Mirror of the block state
  tree_entry_t       tree_mem [1 << IDX_W];
  logic [IDX_W-1:0]  walk_node;
  logic [CNT_W-1:0]  decoded_cnt;
  logic [QUAL_W-1:0] quality_q;
  logic [CNT_W-1:0]  symbol_total_q;

  // Pixels still owed by the block, oldest first
  res_t pixel_queue [$];
  res_t want;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_cnt_o++;
  endtask

  // Decoded symbol scaled by the quality multiplier, wrapped to 8 bits
  function automatic res_t pixel_of(input logic [SYM_W-1:0] sym);
    logic [PIX_W-1:0] mult;
    res_t             r;
    mult          = PIX_W'(MULT_BASE - int'(quality_q));
    r.pixel_value = PIX_W'(sym * mult);
    r.status      = STATUS_SYMBOL;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Walk one bitstream byte MSB first and queue the pixels it yields
  task automatic walk_byte(input in_t it);
    res_t             run [$];
    res_t             r;
    logic [IDX_W-1:0] nxt;
    int               b;
    for (b = BYTE_BITS - 1; b >= 0 && decoded_cnt < symbol_total_q; b--) begin
      if (tree_mem[walk_node].leaf) begin
        // leaf at the root: each bit emits it again
        run.push_back(pixel_of(tree_mem[walk_node].symbol));
        decoded_cnt++;
        walk_node = '0;
      end else begin
        nxt = it.data_byte[b] ? tree_mem[walk_node].right : tree_mem[walk_node].left;
        if (tree_mem[nxt].leaf) begin
          run.push_back(pixel_of(tree_mem[nxt].symbol));
          decoded_cnt++;
          walk_node = '0;
        end else begin
          walk_node = nxt;
        end
      end
    end
    // last byte ended inside a code while symbols are still owed
    if (it.final_byte) begin
      if (decoded_cnt < symbol_total_q && walk_node != '0 && run.size() < BYTE_BITS) begin
        r        = '0;
        r.status = STATUS_EXHAUSTED;
        run.push_back(r);
      end
      walk_node = '0;
    end
    foreach (run[i]) begin
      r             = run[i];
      r.last_of_run = (i == run.size() - 1);
      pixel_queue.push_back(r);
    end
  endtask

  // Follow the three channels at each edge: config, command, then results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_node      = '0;
      decoded_cnt    = '0;
      quality_q      = QUAL_W'(1);
      symbol_total_q = '0;
      pixel_queue.delete();
      mismatch_cnt_o = 0;
      pending_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_QUALITY: quality_q = cfg_data_i[QUAL_W-1:0];
          CFG_TOTAL:   symbol_total_q = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        if (item_i.op == OP_BYTE) begin
          walk_byte(item_i);
        end else begin
          // node write: store, back to the root, count cleared
          tree_mem[item_i.node_index] = {item_i.node_is_leaf, item_i.node_symbol,
                                         item_i.left_child, item_i.right_child};
          walk_node   = '0;
          decoded_cnt = '0;
        end
      end

      if (res_valid_i) begin
        if (pixel_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected beat pixel=%02h status=%0b last=%0b",
                                    res_i.pixel_value, res_i.status, res_i.last_of_run));
        end else begin
          want = pixel_queue.pop_front();
          if (res_i.pixel_value !== want.pixel_value || res_i.status !== want.status ||
              res_i.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf(
              "pixel=%02h status=%0b last=%0b, expected pixel=%02h status=%0b last=%0b",
              res_i.pixel_value, res_i.status, res_i.last_of_run,
              want.pixel_value, want.status, want.last_of_run));
          end
        end
      end

      pending_o <= pixel_queue.size();
    end
  end

endmodule

>>> sim/huffman_tree_bit_decoder_top_tb.sv
// Testbench top for the Huffman tree bit decoder: directed code trees and
// bytes, then random code trees and byte streams with random idle gaps.
// Depends on hbd_pkg, huffman_tree_bit_decoder_top and hbd_stream_checker.
module huffman_tree_bit_decoder_top_tb;
  import hbd_pkg::*;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  in_t                   item_i      = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  res_valid_o;
  res_t                  res_o;

  int mismatch_cnt;
  int pending_cnt;
  int items_sent;
  bit quiet_phase;

  // Entries of the current code tree; position 0 is the root
  logic [IDX_W-1:0] code_nodes [$];

  always #2 clk_i = ~clk_i;

  huffman_tree_bit_decoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  hbd_stream_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .res_valid_i    (res_valid_o),
    .res_i          (res_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // Idle gap after a beat: mostly none or short, now and then long
  function automatic int gap_cycles();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Random fill for every field, so unused fields toggle too
  function automatic in_t junk_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(in_t)-1:0];
  endfunction

  // One command beat; start stays high when no gap follows
  task automatic send_item(input in_t it);
    int g;
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    g = gap_cycles();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_node(input logic [IDX_W-1:0] idx, input logic leaf,
                           input logic [SYM_W-1:0] sym,
                           input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc);
    in_t it;
    it              = junk_item();
    it.op           = OP_NODE;
    it.node_index   = idx;
    it.node_is_leaf = leaf;
    it.node_symbol  = sym;
    it.left_child   = lc;
    it.right_child  = rc;
    send_item(it);
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] data, input logic fin);
    in_t it;
    it            = junk_item();
    it.op         = OP_BYTE;
    it.data_byte  = data;
    it.final_byte = fin;
    send_item(it);
  endtask

  // Children only point deeper into the tree (or, rarely, back to the root),
  // so every walk reaches a leaf and never touches an unwritten entry
  function automatic logic [IDX_W-1:0] pick_child(input int p);
    if ($urandom_range(0, 15) == 0) return '0;
    return code_nodes[$urandom_range(p + 1, code_nodes.size() - 1)];
  endfunction

  task automatic write_code_node(input int p);
    in_t it;
    int  last;
    last            = code_nodes.size() - 1;
    it              = junk_item();
    it.op           = OP_NODE;
    it.node_index   = code_nodes[p];
    it.node_is_leaf = (p == last) || (p > 0 && $urandom_range(0, 3) == 0);
    if (!it.node_is_leaf) begin
      it.left_child  = pick_child(p);
      it.right_child = pick_child(p);
    end
    send_item(it);
  endtask

  // Quiet block: every expected beat in, then time for zero-result bytes
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Both registers, with junk above the quality bits and a stray index now and then
  task automatic set_config(input logic [QUAL_W-1:0] q, input logic [CNT_W-1:0] total);
    logic [CFG_DATA_W-1:0] qword;
    wait_idle();
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_TOTAL) + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    qword             = CFG_DATA_W'($urandom);
    qword[QUAL_W-1:0] = q;
    write_reg(CFG_QUALITY, qword);
    write_reg(CFG_TOTAL, CFG_DATA_W'(total));
    cfg_valid_i <= 1'b0;
  endtask

  // Run limit
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int               n_nodes;
    int               n_bytes;
    logic [IDX_W-1:0] idx;
    logic [QUAL_W-1:0] q;
    logic [CNT_W-1:0] tot;
    bit               index_taken [1 << IDX_W];

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: root splits to a leaf and to the top entry of the table
    set_config(4'd10, 24'hFFFFFF);
    send_node(9'd0, 1'b0, 8'h00, 9'd1, 9'd511);
    send_node(9'd1, 1'b1, 8'hFF, 9'd0, 9'd0);
    send_node(9'd511, 1'b0, 8'h00, 9'd2, 9'd3);
    send_node(9'd2, 1'b1, 8'h00, 9'd511, 9'd511);
    send_node(9'd3, 1'b1, 8'h5A, 9'd0, 9'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    // seven symbols, then the final byte stops inside a code
    send_byte(8'h01, 1'b1);

    // Multiplier 11, total of three: emission stops mid-byte
    set_config(4'd0, 24'd3);
    send_node(9'd1, 1'b1, 8'hFF, 9'd0, 9'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // Quality 15 wraps the multiplier
    set_config(4'd15, 24'd2);
    send_node(9'd2, 1'b1, 8'h01, 9'd0, 9'd0);
    send_byte(8'hA5, 1'b0);

    // Zero total decodes nothing
    set_config(4'd1, 24'd0);
    send_node(9'd3, 1'b1, 8'h77, 9'd0, 9'd0);
    send_byte(8'h3C, 1'b1);

    // Leaf at the root emits on every bit
    set_config(4'd9, 24'd5);
    send_node(9'd0, 1'b1, 8'h81, 9'd0, 9'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Random phases: new settings, a fresh code tree, then a byte stream
    items_sent = 0;
    while (items_sent < 420) begin
      quiet_phase = ($urandom_range(0, 3) == 0);
      q = ($urandom_range(0, 4) == 0) ? QUAL_W'($urandom) : QUAL_W'($urandom_range(1, 10));
      case ($urandom_range(0, 9))
        0:       tot = '0;
        1:       tot = '1;
        7, 8, 9: tot = CNT_W'($urandom);
        default: tot = CNT_W'($urandom_range(1, 60));
      endcase
      set_config(q, tot);

      n_nodes = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(2, 10);
      code_nodes.delete();
      foreach (index_taken[i]) index_taken[i] = 1'b0;
      code_nodes.push_back('0);
      index_taken[0] = 1'b1;
      while (code_nodes.size() < n_nodes) begin
        idx = IDX_W'($urandom_range(1, (1 << IDX_W) - 1));
        if (!index_taken[idx]) begin
          index_taken[idx] = 1'b1;
          code_nodes.push_back(idx);
        end
      end
      for (int p = 0; p < n_nodes; p++) write_code_node(p);

      // occasional node rewrite mid-stream restarts the walk and the count
      n_bytes = $urandom_range(8, 30);
      for (int i = 0; i < n_bytes; i++) begin
        if ($urandom_range(0, 19) == 0) write_code_node($urandom_range(0, n_nodes - 1));
        send_byte(DATA_W'($urandom), (i == n_bytes - 1) || ($urandom_range(0, 5) == 0));
      end
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> huffman_tree_bit_decoder_top.f
+incdir+sv
sv/hbd_pkg.sv
sv/hbd_front.sv
sv/hbd_fifo.sv
sv/hbd_back.sv
sv/huffman_tree_bit_decoder_top.sv
sim/hbd_stream_checker.sv
sim/huffman_tree_bit_decoder_top_tb.sv
